// File: src/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants for the red line blob steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package rls_pkg;

    localparam int LINE_PIXELS_DEF  = 80;
    localparam int CENTRE_START_DEF = 38;
    localparam int CENTRE_WIDTH_DEF = 6;

    localparam int PIXEL_W  = 16;
    localparam int MARGIN_W = 9;
    localparam int SIDE_W   = 6;
    localparam int CENTRE_W = 3;
    localparam int ACTION_W = 2;

    localparam logic [SIDE_W-1:0]   SIDE_MAX   = '1;
    localparam logic [CENTRE_W-1:0] CENTRE_MAX = '1;
    localparam logic [CENTRE_W-1:0] CHARGE_MIN = CENTRE_W'(3);

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_STOP       = 2'd0,
        ACT_CHARGE     = 2'd1,
        ACT_SPIN_LEFT  = 2'd2,
        ACT_SPIN_RIGHT = 2'd3
    } t_action;

    typedef struct packed {
        logic is_red;
        logic is_left;
        logic in_centre;
        logic last;
    } t_item;

endpackage

`default_nettype wire

// File: src/red_line_blob_steer_top.sv
// ----------------------------------------------------------------------------
// red_line_blob_steer_top
// Streaming red blob detector giving a steering action once per camera line.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one RGB565 pixel per request,
// first camera byte in bits 15..8. Output channel (o_out_valid / i_out_ready)
// returns one result per pixel, in order: red flag, end-of-line flag,
// action (valid on end of line) and the running left/right red counts.
// Config channel (i_cfg_valid / o_cfg_ready) writes the signed red margin;
// it is always ready and is to be written only while the block is idle.
// Throughput: one pixel per cycle while the receiver takes results. A pixel
// enters a two-entry queue at the edge that accepts it and moves on to the
// output register when the back part pops it, which waits out a stall.
// Reset clears the margin, the line position, the counts and the queue.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to two more pixels before o_in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module red_line_blob_steer_top #(
    parameter int LINE_PIXELS  = rls_pkg::LINE_PIXELS_DEF,
    parameter int CENTRE_START = rls_pkg::CENTRE_START_DEF,
    parameter int CENTRE_WIDTH = rls_pkg::CENTRE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rls_pkg::MARGIN_W-1:0]  i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [rls_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_is_red,
    output logic                               o_line_done,
    output logic [rls_pkg::ACTION_W-1:0]       o_action,
    output logic [rls_pkg::SIDE_W-1:0]         o_left_red,
    output logic [rls_pkg::SIDE_W-1:0]         o_right_red
);

    rls_pkg::t_item   front_item;
    rls_pkg::t_item   queue_item;
    rls_pkg::t_action action;
    logic             queue_full;
    logic             queue_valid;
    logic             pop;
    logic             accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !queue_full;
    assign accept      = i_in_valid && !queue_full;
    assign o_action    = action;

    rls_front #(
        .LINE_PIXELS  (LINE_PIXELS),
        .CENTRE_START (CENTRE_START),
        .CENTRE_WIDTH (CENTRE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_pixel),
        .o_item      (front_item)
    );

    rls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    rls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_is_red    (o_is_red),
        .o_line_done (o_line_done),
        .o_action    (action),
        .o_left_red  (o_left_red),
        .o_right_red (o_right_red)
    );

endmodule

`default_nettype wire

// File: src/rls_front.sv
// ----------------------------------------------------------------------------
// rls_front
// Classifies each accepted pixel (red test, side, centre window, end of line)
// and tracks the position within the line.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_front #(
    parameter int LINE_PIXELS  = rls_pkg::LINE_PIXELS_DEF,
    parameter int CENTRE_START = rls_pkg::CENTRE_START_DEF,
    parameter int CENTRE_WIDTH = rls_pkg::CENTRE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [rls_pkg::MARGIN_W-1:0]  i_cfg_data,
    input  wire logic                          i_accept,
    input  wire logic [rls_pkg::PIXEL_W-1:0]   i_pixel,
    output rls_pkg::t_item                     o_item
);

    localparam int IDX_W = $clog2(LINE_PIXELS);

    logic [IDX_W-1:0]             r_idx;
    logic [IDX_W-1:0]             n_idx;
    logic [rls_pkg::MARGIN_W-1:0] r_margin;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic signed [10:0]           red_s;
    logic signed [10:0]           limit_s;
    logic [31:0]                  idx_ext;

    assign red     = {i_pixel[15:11], 3'b000};
    assign green   = {i_pixel[10:8], i_pixel[7:5], 2'b00};
    assign red_s   = $signed({3'b000, red});
    assign limit_s = $signed({3'b000, green}) + $signed({{2{r_margin[8]}}, r_margin});
    assign idx_ext = 32'(r_idx);

    always_comb begin
        o_item.is_red    = red_s > limit_s;
        o_item.is_left   = idx_ext < 32'(LINE_PIXELS / 2);
        o_item.in_centre = (idx_ext >= 32'(CENTRE_START)) &&
                           (idx_ext < 32'(CENTRE_START + CENTRE_WIDTH));
        o_item.last      = idx_ext >= 32'(LINE_PIXELS - 1);
        n_idx            = o_item.last ? '0 : r_idx + IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_margin <= '0;
        end else begin
            if (i_accept) begin
                r_idx <= n_idx;
            end
            if (i_cfg_valid) begin
                r_margin <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/rls_queue.sv
// ----------------------------------------------------------------------------
// rls_queue
// Short queue of classified pixels between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire rls_pkg::t_item i_item,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output rls_pkg::t_item o_item
);

    localparam int PTR_W = $clog2(rls_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rls_pkg::QUEUE_DEPTH + 1);

    rls_pkg::t_item   r_mem [rls_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(rls_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (32'(r_wptr) == rls_pkg::QUEUE_DEPTH - 1) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (32'(r_rptr) == rls_pkg::QUEUE_DEPTH - 1) ? '0 : r_rptr + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("queue push while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= rls_pkg::QUEUE_DEPTH)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: src/rls_back.sv
// ----------------------------------------------------------------------------
// rls_back
// Accumulates red counts per line, decides the steering action on the last
// pixel and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire rls_pkg::t_item                i_item,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_is_red,
    output logic                               o_line_done,
    output rls_pkg::t_action                   o_action,
    output logic [rls_pkg::SIDE_W-1:0]         o_left_red,
    output logic [rls_pkg::SIDE_W-1:0]         o_right_red
);

    logic [rls_pkg::SIDE_W-1:0]   r_left;
    logic [rls_pkg::SIDE_W-1:0]   r_right;
    logic [rls_pkg::CENTRE_W-1:0] r_centre;
    logic [rls_pkg::SIDE_W-1:0]   n_left;
    logic [rls_pkg::SIDE_W-1:0]   n_right;
    logic [rls_pkg::CENTRE_W-1:0] n_centre;
    rls_pkg::t_action             n_action;

    logic                         r_valid;
    logic                         r_is_red;
    logic                         r_line_done;
    rls_pkg::t_action             r_action;
    logic [rls_pkg::SIDE_W-1:0]   r_left_red;
    logic [rls_pkg::SIDE_W-1:0]   r_right_red;

    assign o_pop = i_valid && (!r_valid || i_out_ready);

    always_comb begin
        n_left   = r_left;
        n_right  = r_right;
        n_centre = r_centre;
        if (i_item.is_red) begin
            if (i_item.is_left) begin
                if (r_left != rls_pkg::SIDE_MAX) n_left = r_left + rls_pkg::SIDE_W'(1);
            end else begin
                if (r_right != rls_pkg::SIDE_MAX) n_right = r_right + rls_pkg::SIDE_W'(1);
            end
            if (i_item.in_centre && r_centre != rls_pkg::CENTRE_MAX) begin
                n_centre = r_centre + rls_pkg::CENTRE_W'(1);
            end
        end
        priority if (!i_item.last) begin
            n_action = rls_pkg::ACT_STOP;
        end else if (n_centre > rls_pkg::CHARGE_MIN) begin
            n_action = rls_pkg::ACT_CHARGE;
        end else if (n_left != '0 || n_right != '0) begin
            n_action = (n_left < n_right) ? rls_pkg::ACT_SPIN_LEFT : rls_pkg::ACT_SPIN_RIGHT;
        end else begin
            n_action = rls_pkg::ACT_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_left   <= '0;
            r_right  <= '0;
            r_centre <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_item.last) begin
                    r_left   <= '0;
                    r_right  <= '0;
                    r_centre <= '0;
                end else begin
                    r_left   <= n_left;
                    r_right  <= n_right;
                    r_centre <= n_centre;
                end
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_red    <= i_item.is_red;
            r_line_done <= i_item.last;
            r_action    <= n_action;
            r_left_red  <= n_left;
            r_right_red <= n_right;
        end
    end

    assign o_out_valid = r_valid;
    assign o_is_red    = r_is_red;
    assign o_line_done = r_line_done;
    assign o_action    = r_action;
    assign o_left_red  = r_left_red;
    assign o_right_red = r_right_red;

    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |=> r_left == '0 && r_right == '0 && r_centre == '0)
        else $error("counts not cleared after end of line");

    a_action_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_line_done |-> r_action == rls_pkg::ACT_STOP)
        else $error("action given before end of line");

    a_centre_needs_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_centre != '0 |-> r_left != '0 || r_right != '0)
        else $error("centre count without side count");

endmodule

`default_nettype wire

// File: sim/tb_red_line_blob_steer_top.sv
// ----------------------------------------------------------------------------
// tb_red_line_blob_steer_top
// Pixel classification, red counts and end-of-line steering against a model.
// ----------------------------------------------------------------------------
// Pixels go in over the input channel. A predictor classifies each accepted
// pixel with the current margin, keeps its own line position and counts, and
// queues the result it should give. Each result taken from the output
// channel is checked field by field against the oldest queued result.
// Directed pixels cover the field and margin extremes. Random camera lines
// are then shaped to give every steering action. The margin changes only
// while the block is idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_red_line_blob_steer_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF        = rls_pkg::LINE_PIXELS_DEF / 2;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic                         is_red;
        logic                         line_done;
        rls_pkg::t_action             action;
        logic [rls_pkg::SIDE_W-1:0]   left_red;
        logic [rls_pkg::SIDE_W-1:0]   right_red;
    } t_blob_result;

    typedef enum {
        PAT_QUIET,
        PAT_LEFT,
        PAT_RIGHT,
        PAT_CHARGE,
        PAT_NEAR_CHARGE,
        PAT_BALANCED,
        PAT_NOISE
    } t_line_pattern;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rls_pkg::MARGIN_W-1:0]   i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [rls_pkg::PIXEL_W-1:0]    i_pixel;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic                           o_is_red;
    logic                           o_line_done;
    logic [rls_pkg::ACTION_W-1:0]   o_action;
    logic [rls_pkg::SIDE_W-1:0]     o_left_red;
    logic [rls_pkg::SIDE_W-1:0]     o_right_red;

    t_blob_result                   expected_results[$];
    int                             margin_val;
    int                             line_pos;
    logic [rls_pkg::SIDE_W-1:0]     left_cnt;
    logic [rls_pkg::SIDE_W-1:0]     right_cnt;
    logic [rls_pkg::CENTRE_W-1:0]   center_cnt;
    int                             error_count;
    int                             cycle_count;
    int                             src_idle_pct   = 35;
    int                             sink_stall_pct = 70;

    red_line_blob_steer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_is_red    (o_is_red),
        .o_line_done (o_line_done),
        .o_action    (o_action),
        .o_left_red  (o_left_red),
        .o_right_red (o_right_red)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit in_center_window(input int pos);
        return pos >= rls_pkg::CENTRE_START_DEF &&
               pos < rls_pkg::CENTRE_START_DEF + rls_pkg::CENTRE_WIDTH_DEF;
    endfunction

    function automatic bit is_red_pixel(input logic [rls_pkg::PIXEL_W-1:0] px);
        int red_lvl;
        int green_lvl;
        red_lvl   = int'({px[15:11], 3'b000});
        green_lvl = int'({px[10:8], px[7:5], 2'b00});
        return red_lvl > green_lvl + margin_val;
    endfunction

    // Random pixel of the wanted class; falls back to any pixel if the margin
    // makes that class unreachable.
    function automatic logic [rls_pkg::PIXEL_W-1:0] make_pixel(input bit want_red);
        logic [rls_pkg::PIXEL_W-1:0] px;
        px = rls_pkg::PIXEL_W'($urandom);
        for (int tries = 0; tries < 64 && is_red_pixel(px) != want_red; tries++)
            px = rls_pkg::PIXEL_W'($urandom);
        return px;
    endfunction

    function automatic bit want_red(input t_line_pattern pat, input int pos,
                                    input logic [HALF-1:0] mask);
        bit on_left;
        bit center;
        int side_pos;
        int roll;
        on_left  = pos < HALF;
        center   = in_center_window(pos);
        side_pos = pos % HALF;
        roll     = $urandom_range(99);
        case (pat)
            PAT_QUIET:       return 1'b0;
            PAT_LEFT:        return !center && roll < (on_left ? 50 : 10);
            PAT_RIGHT:       return !center && roll < (on_left ? 10 : 50);
            PAT_CHARGE:      return center || roll < 20;
            PAT_NEAR_CHARGE: return center ? pos < rls_pkg::CENTRE_START_DEF + 3 : roll < 20;
            PAT_BALANCED:    return mask[side_pos] && !in_center_window(side_pos)
                                    && !in_center_window(side_pos + HALF);
            default:         return roll < 50;
        endcase
    endfunction

    task automatic predict_pixel(input logic [rls_pkg::PIXEL_W-1:0] px);
        t_blob_result res;
        bit hot;
        hot = is_red_pixel(px);
        if (hot) begin
            if (line_pos < HALF) begin
                if (left_cnt != rls_pkg::SIDE_MAX) left_cnt++;
            end else if (right_cnt != rls_pkg::SIDE_MAX) begin
                right_cnt++;
            end
            if (in_center_window(line_pos) && center_cnt != rls_pkg::CENTRE_MAX) begin
                center_cnt++;
            end
        end
        res.is_red    = hot;
        res.line_done = line_pos >= rls_pkg::LINE_PIXELS_DEF - 1;
        res.action    = rls_pkg::ACT_STOP;
        res.left_red  = left_cnt;
        res.right_red = right_cnt;
        if (res.line_done) begin
            if (center_cnt > rls_pkg::CHARGE_MIN) begin
                res.action = rls_pkg::ACT_CHARGE;
            end else if (left_cnt != '0 || right_cnt != '0) begin
                if (left_cnt < right_cnt) res.action = rls_pkg::ACT_SPIN_LEFT;
                else res.action = rls_pkg::ACT_SPIN_RIGHT;
            end
            line_pos   = 0;
            left_cnt   = '0;
            right_cnt  = '0;
            center_cnt = '0;
        end else begin
            line_pos++;
        end
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic check_result();
        t_blob_result want;
        if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, %s %0b %0b %0d %0d %0d",
                     $time, "actual red/done/act/L/R", o_is_red, o_line_done,
                     o_action, o_left_red, o_right_red);
            return;
        end
        want = expected_results.pop_front();
        check_field("is_red", 8'(want.is_red), 8'(o_is_red));
        check_field("line_done", 8'(want.line_done), 8'(o_line_done));
        check_field("action", 8'(want.action), 8'(o_action));
        check_field("left_red", 8'(want.left_red), 8'(o_left_red));
        check_field("right_red", 8'(want.right_red), 8'(o_right_red));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result();
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Valid stays high between back-to-back requests; it only drops on idle.
    task automatic send_pixel(input logic [rls_pkg::PIXEL_W-1:0] px);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_pixel(px);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_margin(input int value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rls_pkg::MARGIN_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        margin_val = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_pixel_extremes();
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        send_pixel(16'h001F);
        send_pixel(16'h0840);   // red equals green
        send_pixel(16'h1040);   // red one step above green
        send_pixel(16'hF81F);
    endtask

    task automatic test_margin_extremes();
        write_margin(-256);
        send_pixel(16'h07E0);
        send_pixel(16'h0000);
        write_margin(255);
        send_pixel(16'hF800);
        send_pixel(16'h0000);
        write_margin(-1);
        send_pixel(16'h0840);
        write_margin(1);
        send_pixel(16'h1040);
        send_pixel(16'h0840);
        write_margin(8);
        send_pixel(16'h1040);
    endtask

    task automatic test_steering_lines(input int n_items);
        t_line_pattern    pat;
        logic [HALF-1:0]  mask;
        int               sent;
        sent = 0;
        while (sent < n_items) begin
            pat  = t_line_pattern'($urandom_range(int'(PAT_NOISE)));
            mask = HALF'({$urandom, $urandom});
            do begin
                send_pixel(make_pixel(want_red(pat, line_pos, mask)));
                sent++;
            end while (line_pos != 0 && sent < n_items);
        end
    endtask

    task automatic test_saturated_margins();
        write_margin(-256);
        test_steering_lines(rls_pkg::LINE_PIXELS_DEF);
        write_margin(255);
        test_steering_lines(rls_pkg::LINE_PIXELS_DEF);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pixel     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_out_ready <= 1'b0;
        margin_val  = 0;
        line_pos    = 0;
        left_cnt    = '0;
        right_cnt   = '0;
        center_cnt  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_pixel_extremes();
        test_margin_extremes();

        write_margin(int'($urandom_range(60)) - 30);
        test_steering_lines(170);

        src_idle_pct   = 70;
        sink_stall_pct = 35;
        write_margin(-int'($urandom_range(90)));
        test_steering_lines(170);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_margin(int'($urandom_range(90)));
        test_steering_lines(170);
        test_saturated_margins();

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
